// ----- rtl/core/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhp_pkg: shared definitions for the HTTP request head parser
// Character constants, result codes, state encodings and byte classifiers.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam int DEF_LENGTH_WIDTH = 32;
   localparam int BODY_OUT_WIDTH   = 32;

   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_H      = 8'h48;
   localparam logic [7:0] CH_T      = 8'h54;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [31:0] METHOD_GET  = 32'h0047_4554;
   localparam logic [31:0] METHOD_POST = 32'h504F_5354;

   localparam logic [2:0] MLEN_GET  = 3'd3;
   localparam logic [2:0] MLEN_POST = 3'd4;
   localparam logic [2:0] MLEN_SAT  = 3'd5;

   localparam logic [3:0] CL_NAME_LEN = 4'd14;
   // Value sub-state kept in the name match index once the name matched.
   localparam logic [3:0] VAL_LEAD   = 4'd0;
   localparam logic [3:0] VAL_DIGITS = 4'd1;
   localparam logic [3:0] VAL_STOP   = 4'd2;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_GOOD    = 2'd1,
      ST_BAD     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PART_NONE   = 3'd0,
      PART_METHOD = 3'd1,
      PART_URI    = 3'd2,
      PART_NAME   = 3'd3,
      PART_VALUE  = 3'd4,
      PART_BODY   = 3'd5
   } part_type;

   typedef enum logic [1:0] {
      MC_UNKNOWN = 2'd0,
      MC_GET     = 2'd1,
      MC_POST    = 2'd2
   } method_code_type;

   typedef enum logic [17:0] {
      PS_START  = 18'h00001,
      PS_METHOD = 18'h00002,
      PS_URI    = 18'h00004,
      PS_VH     = 18'h00008,
      PS_VT1    = 18'h00010,
      PS_VT2    = 18'h00020,
      PS_VP     = 18'h00040,
      PS_VSLASH = 18'h00080,
      PS_MAJ0   = 18'h00100,
      PS_MAJ    = 18'h00200,
      PS_MIN0   = 18'h00400,
      PS_MIN    = 18'h00800,
      PS_NL1    = 18'h01000,
      PS_HLS    = 18'h02000,
      PS_HL     = 18'h04000,
      PS_NL2    = 18'h08000,
      PS_NL3    = 18'h10000,
      PS_BODY   = 18'h20000
   } parse_state_type;

   typedef enum logic [6:0] {
      HP_PRE    = 7'h01,
      HP_NAME   = 7'h02,
      HP_PREVAL = 7'h04,
      HP_VAL    = 7'h08,
      HP_EPRE   = 7'h10,
      HP_EVAL   = 7'h20,
      HP_NAMEWS = 7'h40
   } header_phase_type;

   typedef struct packed {
      status_type                  status;
      logic [7:0]                  byte_out;
      part_type                    part;
      method_code_type             method_code;
      logic [7:0]                  version_major;
      logic [7:0]                  version_minor;
      logic [BODY_OUT_WIDTH-1:0]   body_remaining;
   } result_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c >= 8'h41 && c <= 8'h5A;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SP || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_cntrl(input logic [7:0] c);
      return c < 8'h20 || c == 8'h7F;
   endfunction

   // Lower-case spelling of the Content-Length header name.
   function automatic logic [7:0] cl_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:  ch = 8'h63;
         4'd1:  ch = 8'h6F;
         4'd2:  ch = 8'h6E;
         4'd3:  ch = 8'h74;
         4'd4:  ch = 8'h65;
         4'd5:  ch = 8'h6E;
         4'd6:  ch = 8'h74;
         4'd7:  ch = 8'h2D;
         4'd8:  ch = 8'h6C;
         4'd9:  ch = 8'h65;
         4'd10: ch = 8'h6E;
         4'd11: ch = 8'h67;
         4'd12: ch = 8'h74;
         4'd13: ch = 8'h68;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/core/hrhp_step.sv -----
// ----------------------------------------------------------------------------
// hrhp_step: parser state and per-byte transition
// Holds the parse state and computes the tag and result fields of one beat.
// ----------------------------------------------------------------------------
module hrhp_step #(
   parameter int LENGTH_WIDTH = hrhp_pkg::DEF_LENGTH_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  cmd,
   input  logic [7:0]            byte_in,
   output hrhp_pkg::result_type  result
);

   localparam int BW = hrhp_pkg::BODY_OUT_WIDTH;

   hrhp_pkg::parse_state_type  state_ff, state_in;
   hrhp_pkg::header_phase_type hphase_ff, hphase_in;
   logic [31:0]             mchars_ff, mchars_in;
   logic [2:0]              mlen_ff, mlen_in;
   logic [7:0]              major_ff, major_in;
   logic [7:0]              minor_ff, minor_in;
   logic [3:0]              midx_ff, midx_in;
   logic                    mok_ff, mok_in;
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic                    neg_ff, neg_in;
   logic [LENGTH_WIDTH-1:0] body_ff, body_in;
   logic                    done_ff, done_in;

   logic [3:0]              digit;
   logic [11:0]             major_x10, minor_x10;
   logic [7:0]              major_acc, minor_acc;
   logic [LENGTH_WIDTH+3:0] len_x10;
   logic [LENGTH_WIDTH-1:0] len_acc;
   logic [7:0]              lower;
   logic [BW-1:0]           body_out;

   hrhp_pkg::status_type      status;
   hrhp_pkg::part_type        part;
   hrhp_pkg::method_code_type mcode;

   assign digit = 4'(byte_in - hrhp_pkg::CH_ZERO);
   assign lower = hrhp_pkg::is_upper(byte_in) ? byte_in + hrhp_pkg::CASE_OFFSET : byte_in;

   // Times ten by shift and add; anything past eight bits clamps at 255.
   assign major_x10 = ({4'b0, major_ff} << 3) + ({4'b0, major_ff} << 1) + {8'b0, digit};
   assign minor_x10 = ({4'b0, minor_ff} << 3) + ({4'b0, minor_ff} << 1) + {8'b0, digit};
   assign major_acc = (|major_x10[11:8]) ? 8'hFF : major_x10[7:0];
   assign minor_acc = (|minor_x10[11:8]) ? 8'hFF : minor_x10[7:0];

   // The length clamps at all ones whenever the new value needs more bits.
   assign len_x10 = ({4'b0, len_ff} << 3) + ({4'b0, len_ff} << 1)
                    + {{LENGTH_WIDTH{1'b0}}, digit};
   assign len_acc = (|len_x10[LENGTH_WIDTH+3:LENGTH_WIDTH]) ? '1
                    : len_x10[LENGTH_WIDTH-1:0];

   always_comb begin
      logic hdr;
      hdr       = 1'b0;
      state_in  = state_ff;
      hphase_in = hphase_ff;
      mchars_in = mchars_ff;
      mlen_in   = mlen_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      midx_in   = midx_ff;
      mok_in    = mok_ff;
      len_in    = len_ff;
      neg_in    = neg_ff;
      body_in   = body_ff;
      done_in   = done_ff;
      status    = hrhp_pkg::ST_PENDING;
      part      = hrhp_pkg::PART_NONE;

      if (cmd) begin
         state_in  = hrhp_pkg::PS_START;
         hphase_in = hrhp_pkg::HP_PRE;
         mchars_in = '0;
         mlen_in   = '0;
         major_in  = '0;
         minor_in  = '0;
         midx_in   = '0;
         mok_in    = 1'b1;
         len_in    = '0;
         neg_in    = 1'b0;
         body_in   = '0;
         done_in   = 1'b0;
      end else if (done_ff) begin
         status = hrhp_pkg::ST_BAD;
      end else begin
         unique case (state_ff)
            hrhp_pkg::PS_START: begin
               if (hrhp_pkg::is_alpha(byte_in)) begin
                  mchars_in = {24'b0, byte_in};
                  mlen_in   = 3'd1;
                  state_in  = hrhp_pkg::PS_METHOD;
                  part      = hrhp_pkg::PART_METHOD;
               end else begin
                  status = hrhp_pkg::ST_BAD;
               end
            end
            hrhp_pkg::PS_METHOD: begin
               if (byte_in == hrhp_pkg::CH_SP) begin
                  if ((mlen_ff == hrhp_pkg::MLEN_GET && mchars_ff == hrhp_pkg::METHOD_GET) ||
                      (mlen_ff == hrhp_pkg::MLEN_POST && mchars_ff == hrhp_pkg::METHOD_POST))
                  begin
                     state_in = hrhp_pkg::PS_URI;
                  end else begin
                     status = hrhp_pkg::ST_BAD;
                  end
               end else if (!hrhp_pkg::is_alpha(byte_in)) begin
                  status = hrhp_pkg::ST_BAD;
               end else begin
                  if (mlen_ff < hrhp_pkg::MLEN_POST) begin
                     mchars_in = {mchars_ff[23:0], byte_in};
                     mlen_in   = mlen_ff + 3'd1;
                  end else begin
                     mlen_in = hrhp_pkg::MLEN_SAT;
                  end
                  part = hrhp_pkg::PART_METHOD;
               end
            end
            hrhp_pkg::PS_URI: begin
               if (byte_in == hrhp_pkg::CH_SP) state_in = hrhp_pkg::PS_VH;
               else if (hrhp_pkg::is_cntrl(byte_in)) status = hrhp_pkg::ST_BAD;
               else part = hrhp_pkg::PART_URI;
            end
            hrhp_pkg::PS_VH: begin
               if (byte_in == hrhp_pkg::CH_H) state_in = hrhp_pkg::PS_VT1;
               else status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PS_VT1: begin
               if (byte_in == hrhp_pkg::CH_T) state_in = hrhp_pkg::PS_VT2;
               else status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PS_VT2: begin
               if (byte_in == hrhp_pkg::CH_T) state_in = hrhp_pkg::PS_VP;
               else status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PS_VP: begin
               if (byte_in == hrhp_pkg::CH_P) state_in = hrhp_pkg::PS_VSLASH;
               else status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PS_VSLASH: begin
               if (byte_in == hrhp_pkg::CH_SLASH) begin
                  state_in = hrhp_pkg::PS_MAJ0;
                  major_in = '0;
                  minor_in = '0;
               end else begin
                  status = hrhp_pkg::ST_BAD;
               end
            end
            hrhp_pkg::PS_MAJ0, hrhp_pkg::PS_MAJ: begin
               if (state_ff == hrhp_pkg::PS_MAJ && byte_in == hrhp_pkg::CH_DOT) begin
                  state_in = hrhp_pkg::PS_MIN0;
               end else if (hrhp_pkg::is_digit(byte_in)) begin
                  major_in = major_acc;
                  state_in = hrhp_pkg::PS_MAJ;
               end else begin
                  status = hrhp_pkg::ST_BAD;
               end
            end
            hrhp_pkg::PS_MIN0, hrhp_pkg::PS_MIN: begin
               if (state_ff == hrhp_pkg::PS_MIN && byte_in == hrhp_pkg::CH_CR) begin
                  state_in = hrhp_pkg::PS_NL1;
               end else if (hrhp_pkg::is_digit(byte_in)) begin
                  minor_in = minor_acc;
                  state_in = hrhp_pkg::PS_MIN;
               end else begin
                  status = hrhp_pkg::ST_BAD;
               end
            end
            hrhp_pkg::PS_NL1, hrhp_pkg::PS_NL2: begin
               if (byte_in == hrhp_pkg::CH_LF) state_in = hrhp_pkg::PS_HLS;
               else status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PS_HLS: begin
               if (byte_in == hrhp_pkg::CH_CR) begin
                  state_in = hrhp_pkg::PS_NL3;
               end else begin
                  // A new header line starts with a fresh name match.
                  hphase_in = hrhp_pkg::HP_PRE;
                  midx_in   = '0;
                  mok_in    = 1'b1;
                  hdr       = 1'b1;
                  state_in  = hrhp_pkg::PS_HL;
               end
            end
            hrhp_pkg::PS_HL: begin
               if (byte_in == hrhp_pkg::CH_CR) begin
                  if (hphase_ff == hrhp_pkg::HP_PREVAL || hphase_ff == hrhp_pkg::HP_VAL)
                     state_in = hrhp_pkg::PS_NL2;
                  else
                     status = hrhp_pkg::ST_BAD;
               end else begin
                  hdr = 1'b1;
               end
            end
            hrhp_pkg::PS_NL3: begin
               if (byte_in != hrhp_pkg::CH_LF) begin
                  status = hrhp_pkg::ST_BAD;
               end else if (mchars_ff == hrhp_pkg::METHOD_GET) begin
                  status  = hrhp_pkg::ST_GOOD;
                  done_in = 1'b1;
               end else if (neg_ff || len_ff == '0) begin
                  status = hrhp_pkg::ST_BAD;
               end else begin
                  body_in  = len_ff;
                  state_in = hrhp_pkg::PS_BODY;
               end
            end
            hrhp_pkg::PS_BODY: begin
               part    = hrhp_pkg::PART_BODY;
               body_in = body_ff - 1'b1;
               if (body_in == '0) begin
                  status  = hrhp_pkg::ST_GOOD;
                  done_in = 1'b1;
               end
            end
            default: begin
               status = hrhp_pkg::ST_BAD;
            end
         endcase

         if (hdr) begin
            unique case (hphase_in)
               hrhp_pkg::HP_PRE: begin
                  if (byte_in == hrhp_pkg::CH_COLON) begin
                     hphase_in = hrhp_pkg::HP_EPRE;
                     mok_in    = 1'b0;
                  end else if (!hrhp_pkg::is_space(byte_in)) begin
                     hphase_in = hrhp_pkg::HP_NAME;
                     if (midx_in < hrhp_pkg::CL_NAME_LEN && lower == hrhp_pkg::cl_char(midx_in))
                        midx_in = midx_in + 4'd1;
                     else
                        mok_in = 1'b0;
                     part = hrhp_pkg::PART_NAME;
                  end
               end
               hrhp_pkg::HP_NAME, hrhp_pkg::HP_NAMEWS: begin
                  if (byte_in == hrhp_pkg::CH_COLON) begin
                     if (mok_in && midx_in == hrhp_pkg::CL_NAME_LEN) begin
                        len_in  = '0;
                        neg_in  = 1'b0;
                        midx_in = hrhp_pkg::VAL_LEAD;
                     end else begin
                        mok_in = 1'b0;
                     end
                     hphase_in = hrhp_pkg::HP_PREVAL;
                  end else if (hrhp_pkg::is_space(byte_in)) begin
                     hphase_in = hrhp_pkg::HP_NAMEWS;
                     part      = hrhp_pkg::PART_NAME;
                  end else begin
                     // A name broken by inner whitespace can no longer match.
                     if (hphase_in == hrhp_pkg::HP_NAMEWS) begin
                        mok_in    = 1'b0;
                        hphase_in = hrhp_pkg::HP_NAME;
                     end
                     if (midx_in < hrhp_pkg::CL_NAME_LEN && lower == hrhp_pkg::cl_char(midx_in))
                        midx_in = midx_in + 4'd1;
                     else
                        mok_in = 1'b0;
                     part = hrhp_pkg::PART_NAME;
                  end
               end
               hrhp_pkg::HP_PREVAL, hrhp_pkg::HP_VAL: begin
                  if (hphase_in == hrhp_pkg::HP_PREVAL && hrhp_pkg::is_space(byte_in)) begin
                     part = hrhp_pkg::PART_NONE;
                  end else begin
                     hphase_in = hrhp_pkg::HP_VAL;
                     part      = hrhp_pkg::PART_VALUE;
                     if (mok_in) begin
                        if (midx_in == hrhp_pkg::VAL_LEAD &&
                            (byte_in == hrhp_pkg::CH_PLUS || byte_in == hrhp_pkg::CH_MINUS))
                        begin
                           neg_in  = (byte_in == hrhp_pkg::CH_MINUS);
                           midx_in = hrhp_pkg::VAL_DIGITS;
                        end else if (midx_in <= hrhp_pkg::VAL_DIGITS &&
                                     hrhp_pkg::is_digit(byte_in)) begin
                           len_in  = len_acc;
                           midx_in = hrhp_pkg::VAL_DIGITS;
                        end else begin
                           midx_in = hrhp_pkg::VAL_STOP;
                        end
                     end
                  end
               end
               hrhp_pkg::HP_EPRE: begin
                  if (!hrhp_pkg::is_space(byte_in)) begin
                     hphase_in = hrhp_pkg::HP_EVAL;
                     part      = hrhp_pkg::PART_VALUE;
                  end
               end
               default: begin
                  part = hrhp_pkg::PART_VALUE;
               end
            endcase
         end

         if (status == hrhp_pkg::ST_BAD) part = hrhp_pkg::PART_NONE;
      end
   end

   always_comb begin
      if (state_in == hrhp_pkg::PS_START || state_in == hrhp_pkg::PS_METHOD)
         mcode = hrhp_pkg::MC_UNKNOWN;
      else if (mchars_in == hrhp_pkg::METHOD_GET)
         mcode = hrhp_pkg::MC_GET;
      else
         mcode = hrhp_pkg::MC_POST;
   end

   generate
      if (LENGTH_WIDTH > BW) begin : g_body_sat
         assign body_out = (|body_in[LENGTH_WIDTH-1:BW]) ? '1 : body_in[BW-1:0];
      end else begin : g_body_ext
         assign body_out = BW'(body_in);
      end
   endgenerate

   assign result.status         = status;
   assign result.byte_out       = byte_in;
   assign result.part           = part;
   assign result.method_code    = mcode;
   assign result.version_major  = major_in;
   assign result.version_minor  = minor_in;
   assign result.body_remaining = body_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hrhp_pkg::PS_START;
         hphase_ff <= hrhp_pkg::HP_PRE;
         mchars_ff <= '0;
         mlen_ff   <= '0;
         major_ff  <= '0;
         minor_ff  <= '0;
         midx_ff   <= '0;
         mok_ff    <= 1'b1;
         len_ff    <= '0;
         neg_ff    <= 1'b0;
         body_ff   <= '0;
         done_ff   <= 1'b0;
      end else if (accept) begin
         state_ff  <= state_in;
         hphase_ff <= hphase_in;
         mchars_ff <= mchars_in;
         mlen_ff   <= mlen_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
         midx_ff   <= midx_in;
         mok_ff    <= mok_in;
         len_ff    <= len_in;
         neg_ff    <= neg_in;
         body_ff   <= body_in;
         done_ff   <= done_in;
      end
   end

endmodule

// ----- rtl/core/hrhp_skid.sv -----
// ----------------------------------------------------------------------------
// hrhp_skid: result register with skid entry
// Holds finished result beats so the input side sees a registered stall.
// ----------------------------------------------------------------------------
module hrhp_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hrhp_pkg::result_type  push_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output hrhp_pkg::result_type  out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   hrhp_pkg::result_type main_ff, main_in;
   hrhp_pkg::result_type skid_ff, skid_in;
   logic                 take;

   assign take = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // No push can arrive while the skid entry is occupied.
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !take) begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// ----- rtl/core/http_request_head_parser.sv -----
// ----------------------------------------------------------------------------
// http_request_head_parser: byte-wide HTTP request head checker
// Tags each request byte by part, tracks method, version and body length.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_cmd, req_byte_in
//   rsp     | out       | rsp_valid/rsp_stall  | status, byte, part, method,
//           |           |                      | version, body_remaining
//
// One beat per cycle while req_stall is low; each accepted request beat gives
// one response beat, set by the single transition stage ahead of the result
// register. Synchronous reset returns the parser to its start state and
// empties the result register and skid entry.
// A stalled response fills the skid entry; req_stall rises only while it is
// occupied, so req_stall is a register output.
// ----------------------------------------------------------------------------
module http_request_head_parser #(
   parameter int LENGTH_WIDTH = hrhp_pkg::DEF_LENGTH_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_byte_out,
   output logic [2:0]  rsp_part,
   output logic [1:0]  rsp_method_code,
   output logic [7:0]  rsp_version_major,
   output logic [7:0]  rsp_version_minor,
   output logic [31:0] rsp_body_remaining
);

   logic                 accept;
   hrhp_pkg::result_type step_result;
   hrhp_pkg::result_type rsp_data;

   assign accept = req_valid && !req_stall;

   hrhp_step #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_cmd),
      .byte_in (req_byte_in),
      .result  (step_result)
   );

   hrhp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_result),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_byte_out       = rsp_data.byte_out;
   assign rsp_part           = rsp_data.part;
   assign rsp_method_code    = rsp_data.method_code;
   assign rsp_version_major  = rsp_data.version_major;
   assign rsp_version_minor  = rsp_data.version_minor;
   assign rsp_body_remaining = rsp_data.body_remaining;

endmodule

// ----- rtl/core/hrhp_checker.sv -----
// ----------------------------------------------------------------------------
// hrhp_checker: port-level checks for the HTTP request head parser
// Watches the response channel and the tags it carries over time.
// ----------------------------------------------------------------------------
module hrhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_byte_out,
   input logic [2:0]  rsp_part,
   input logic [1:0]  rsp_method_code,
   input logic [7:0]  rsp_version_major,
   input logic [7:0]  rsp_version_minor,
   input logic [31:0] rsp_body_remaining
);

   // A stalled response beat stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_byte_out) && $stable(rsp_status)
                                 && $stable(rsp_part) && $stable(rsp_method_code)
                                 && $stable(rsp_version_major)
                                 && $stable(rsp_version_minor)
                                 && $stable(rsp_body_remaining))
      else $error("response payload changed while stalled");

   // A rejected byte never carries a part tag.
   a_bad_untagged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == hrhp_pkg::ST_BAD |-> rsp_part == hrhp_pkg::PART_NONE)
      else $error("bad beat tagged with a part");

   // Body bytes only follow a POST head.
   a_body_post: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_part == hrhp_pkg::PART_BODY |-> rsp_method_code == hrhp_pkg::MC_POST)
      else $error("body beat without POST method");

   a_count_needs_method: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_method_code == hrhp_pkg::MC_UNKNOWN |-> rsp_body_remaining == '0)
      else $error("body count set before the method was accepted");

endmodule

bind http_request_head_parser hrhp_checker u_checker (.*);
